// ----- sv/lidar_waveform_return_classifier_unit_macros.svh -----
`ifndef LIDAR_WAVEFORM_RETURN_CLASSIFIER_UNIT_MACROS_SVH
`define LIDAR_WAVEFORM_RETURN_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define LWRC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lwrc assertion failed");

// next-cycle implication, active during reset
`define LWRC_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lwrc assertion failed");

`endif

// ----- sv/lwrc_pkg.sv -----
`default_nettype none
package lwrc_pkg;

   localparam int MAX_BINS = 2048;
   localparam int BIN_W    = $clog2(MAX_BINS);
   localparam int WIN_W    = 11;
   localparam int CMP_W    = ((BIN_W > WIN_W) ? BIN_W : WIN_W) + 3;
   localparam int NUM_REGS = 5;
   localparam int ADDR_W   = $clog2(NUM_REGS) + 2;
   localparam int DATA_W   = 32;

   localparam logic [CMP_W-1:0] SPAN_MARGIN = CMP_W'(5);
   localparam logic [7:0]       COUNT_MAX   = 8'd255;

   localparam logic signed [7:0] PEAK_RESET        = -8'sd125;
   localparam logic [1:0]        MODE_RESET        = 2'd0;
   localparam logic signed [7:0] THRESHOLD_RESET   = -8'sd110;
   localparam logic [7:0]        LIMIT_RESET       = 8'd4;
   localparam logic [WIN_W-1:0]  WINDOW_LOW_RESET  = 11'd933;
   localparam logic [WIN_W-1:0]  WINDOW_HIGH_RESET = 11'd980;

   localparam logic [1:0] MODE_ALL   = 2'd0;
   localparam logic [1:0] MODE_MULTI = 2'd1;
   localparam logic [1:0] MODE_EARLY = 2'd2;

   typedef enum logic [2:0] {
      REG_DETECT_MODE  = 3'd0,
      REG_THRESHOLD    = 3'd1,
      REG_RETURN_LIMIT = 3'd2,
      REG_WINDOW_LOW   = 3'd3,
      REG_WINDOW_HIGH  = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [1:0]        detect_mode;
      logic signed [7:0] threshold;
      logic [7:0]        return_limit;
      logic [WIN_W-1:0]  window_low;
      logic [WIN_W-1:0]  window_high;
   } cfg_type;

endpackage
`default_nettype wire

// ----- sv/lwrc_if.sv -----
`default_nettype none
interface lwrc_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] sample;
   logic              last_bin;

   modport source (output valid, output sample, output last_bin, input ready);
   modport sink (input valid, input sample, input last_bin, output ready);
endinterface

interface lwrc_rsp_if;
   logic       valid;
   logic       ready;
   logic       interesting;
   logic [7:0] return_count;

   modport source (output valid, output interesting, output return_count, input ready);
   modport sink (input valid, input interesting, input return_count, output ready);
endinterface
`default_nettype wire

// ----- sv/lwrc_csr.sv -----
`default_nettype none
module lwrc_csr
   import lwrc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_DETECT_MODE:  cfg_in.detect_mode  = pwdata[1:0];
            REG_THRESHOLD:    cfg_in.threshold    = signed'(pwdata[7:0]);
            REG_RETURN_LIMIT: cfg_in.return_limit = pwdata[7:0];
            REG_WINDOW_LOW:   cfg_in.window_low   = pwdata[WIN_W-1:0];
            REG_WINDOW_HIGH:  cfg_in.window_high  = pwdata[WIN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_DETECT_MODE:  prdata = DATA_W'(cfg_ff.detect_mode);
         REG_THRESHOLD:    prdata = DATA_W'(unsigned'(cfg_ff.threshold));
         REG_RETURN_LIMIT: prdata = DATA_W'(cfg_ff.return_limit);
         REG_WINDOW_LOW:   prdata = DATA_W'(cfg_ff.window_low);
         REG_WINDOW_HIGH:  prdata = DATA_W'(cfg_ff.window_high);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_mode  <= MODE_RESET;
         cfg_ff.threshold    <= THRESHOLD_RESET;
         cfg_ff.return_limit <= LIMIT_RESET;
         cfg_ff.window_low   <= WINDOW_LOW_RESET;
         cfg_ff.window_high  <= WINDOW_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/lwrc_core.sv -----
`default_nettype none
module lwrc_core
   import lwrc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   lwrc_req_if.sink     req_ch,
   lwrc_rsp_if.source   rsp_ch
);

   // input register
   logic              s1_valid_ff;
   logic signed [7:0] s1_sample_ff;
   logic              s1_last_ff;

   // waveform state
   logic [BIN_W:0]    bin_ff,       bin_in;
   logic              in_feat_ff,   in_feat_in;
   logic [7:0]        count_ff,     count_in;
   logic              in_wf_ff,     in_wf_in;
   logic signed [7:0] peak_val_ff,  peak_val_in;
   logic [BIN_W-1:0]  peak_bin_ff,  peak_bin_in;
   logic              hit_ff,       hit_in;

   // result register
   logic       rsp_valid_ff;
   logic       rsp_int_ff,  rsp_int_in;
   logic [7:0] rsp_cnt_ff,  rsp_cnt_in;

   logic out_free;
   logic s1_go;
   logic accept;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_go        = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign accept       = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.interesting  = rsp_int_ff;
   assign rsp_ch.return_count = rsp_cnt_ff;

   always_comb begin
      logic             above;
      logic             in_span;
      logic [CMP_W-1:0] pos_x;
      logic [CMP_W-1:0] pb_x;
      logic [CMP_W-1:0] wl_x;
      logic [CMP_W-1:0] wh_x;

      bin_in      = bin_ff;
      in_feat_in  = in_feat_ff;
      count_in    = count_ff;
      in_wf_in    = in_wf_ff;
      peak_val_in = peak_val_ff;
      peak_bin_in = peak_bin_ff;
      hit_in      = hit_ff;
      rsp_int_in  = 1'b0;
      pb_x        = '0;

      above   = s1_sample_ff > cfg.threshold;
      pos_x   = CMP_W'(bin_ff);
      wl_x    = CMP_W'(cfg.window_low);
      wh_x    = CMP_W'(cfg.window_high);
      in_span = (pos_x < CMP_W'(MAX_BINS)) && (pos_x + SPAN_MARGIN >= wl_x)
                && (pos_x < wh_x + SPAN_MARGIN);

      if (!in_feat_ff) begin
         in_feat_in = above;
      end else if (!above) begin
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 8'd1;
         end
         in_feat_in = 1'b0;
      end

      if (in_span) begin
         if (!in_wf_ff && above) begin
            in_wf_in    = 1'b1;
            peak_val_in = PEAK_RESET;
         end
         if (in_wf_in) begin
            if (s1_sample_ff > peak_val_in) begin
               peak_val_in = s1_sample_ff;
               peak_bin_in = bin_ff[BIN_W-1:0];
            end
            pb_x = CMP_W'(peak_bin_in);
            if (!above) begin
               if (pb_x >= wl_x && pb_x <= wh_x) begin
                  hit_in = 1'b1;
               end
               in_wf_in = 1'b0;
            end
         end
      end else begin
         in_wf_in = 1'b0;
      end

      if (pos_x < CMP_W'(MAX_BINS)) begin
         bin_in = bin_ff + (BIN_W+1)'(1);
      end

      rsp_cnt_in = count_in;

      unique case (cfg.detect_mode)
         MODE_ALL:   rsp_int_in = 1'b1;
         MODE_MULTI: rsp_int_in = count_in > cfg.return_limit;
         MODE_EARLY: rsp_int_in = hit_in;
         default:    rsp_int_in = 1'b0;
      endcase

      if (s1_last_ff) begin
         bin_in     = '0;
         in_feat_in = 1'b0;
         count_in   = '0;
         in_wf_in   = 1'b0;
         hit_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bin_ff       <= '0;
         in_feat_ff   <= 1'b0;
         count_ff     <= '0;
         in_wf_ff     <= 1'b0;
         peak_val_ff  <= PEAK_RESET;
         peak_bin_ff  <= '0;
         hit_ff       <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= accept;
         end
         if (s1_go) begin
            bin_ff      <= bin_in;
            in_feat_ff  <= in_feat_in;
            count_ff    <= count_in;
            in_wf_ff    <= in_wf_in;
            peak_val_ff <= peak_val_in;
            peak_bin_ff <= peak_bin_in;
            hit_ff      <= hit_in;
         end
         if (s1_go && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_ch.sample;
         s1_last_ff   <= req_ch.last_bin;
      end
      if (s1_go && s1_last_ff) begin
         rsp_int_ff <= rsp_int_in;
         rsp_cnt_ff <= rsp_cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/lidar_waveform_return_classifier_unit.sv -----
// Last bins pass the input register; results are held in the result register.
// Throughput: 1 bin per cycle; a last bin waits while a result is stalled.
// A stalled result holds the input register only when it carries a last bin.
// Reset (synchronous): clears waveform state, peak value to -125,
// configuration registers to their defaults.
`default_nettype none
module lidar_waveform_return_classifier_unit
   import lwrc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   lwrc_req_if.sink               req_ch,
   lwrc_rsp_if.source             rsp_ch,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);

   cfg_type cfg;

   lwrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lwrc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule
`default_nettype wire

// ----- sv/lwrc_checker.sv -----
`default_nettype none
`include "lidar_waveform_return_classifier_unit_macros.svh"
module lwrc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_interesting,
   input wire logic [7:0] rsp_return_count
);

   `LWRC_ASSERT_NEXT(a_reset_rsp_idle, clock, reset, !rsp_valid)
   `LWRC_ASSERT_NEXT(a_reset_req_ready, clock, reset, req_ready)
   `LWRC_ASSERT_NOW(a_rsp_hold, clock, reset, $past(rsp_valid && !rsp_ready) && !$past(reset), rsp_valid)
   `LWRC_ASSERT_NOW(a_rsp_stable, clock, reset, $past(rsp_valid && !rsp_ready) && !$past(reset), $stable(rsp_interesting) && $stable(rsp_return_count))

endmodule

bind lidar_waveform_return_classifier_unit lwrc_checker u_lwrc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_interesting  (rsp_ch.interesting),
   .rsp_return_count (rsp_ch.return_count)
);
`default_nettype wire
